// ===== rtl/core/mcbd_pkg.sv =====
package mcbd_pkg;

  // Default depth of the mip chain; the top level takes it as a parameter.
  localparam int unsigned MCBD_MAX_SIDE_LOG2 = 12;
  // Channels per pixel carried by the stream.
  localparam int unsigned MAX_CHANNELS = 4;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = CHAN_W * MAX_CHANNELS;
  localparam int unsigned PAIR_W = (CHAN_W + 1) * MAX_CHANNELS;

  localparam int unsigned SIDE_W = 4;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned POS_W  = 11;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;
  localparam logic [CNT_W-1:0]  CHAN_RESET = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SIDE_LOG2    = 1'b0;
  localparam logic CFG_CHANNEL_CNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_e;

endpackage

// ===== rtl/core/mcbd_ram.sv =====
module mcbd_ram import mcbd_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mcbd_avg.sv =====
module mcbd_avg import mcbd_pkg::*; (
  input  logic [PIX_W-1:0]  held_i,
  input  logic [PIX_W-1:0]  px_i,
  input  logic [PAIR_W-1:0] pair_i,
  output logic [PAIR_W-1:0] pair_sum_o,
  output logic [PIX_W-1:0]  avg_o
);

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chan
    logic [CHAN_W+1:0] sum;

    assign pair_sum_o[c*(CHAN_W+1) +: CHAN_W+1] =
      (CHAN_W+1)'(held_i[c*CHAN_W +: CHAN_W]) + (CHAN_W+1)'(px_i[c*CHAN_W +: CHAN_W]);

    // Four-sample sum with rounding, then divide by four.
    assign sum = (CHAN_W+2)'(pair_i[c*(CHAN_W+1) +: CHAN_W+1])
               + (CHAN_W+2)'(held_i[c*CHAN_W +: CHAN_W])
               + (CHAN_W+2)'(px_i[c*CHAN_W +: CHAN_W])
               + (CHAN_W+2)'(2);
    assign avg_o[c*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
  end

endmodule

// ===== rtl/core/mipmap_chain_box_downsample.sv =====
// Streaming 2x2 box-filter mip chain generator.
// s_axis carries base-level pixels of a square 2^side_log2 texture in raster
// order, one pixel per transfer. m_axis carries one transfer for every new
// lower-level pixel, tagged with its level in tuser and its column and row in
// tdata; tlast marks the last result caused by one input pixel.
// The cfg port writes side_log2 (index 0) and channel_count (index 1); a
// write of side_log2 restarts the raster position of every level.
// Each level visited has a read step, which reads the pair-row memory and
// the held-pixel memory, and an update step. An input that completes no
// block visits only the base level; one that cascades down k extra levels
// visits k more. The first result of an input is loaded into the output
// register by its first update step, once that register is free.
// After reset the position counters are zero, side_log2 is 8 and
// channel_count is 4; the memories need no clearing because raster order
// writes every entry before it is read.
// A result waits in the output register while the receiver stalls. The next
// input is taken meanwhile, and the block holds in its update step only when
// it has a further result and the output register is still occupied.
module mipmap_chain_box_downsample import mcbd_pkg::*; #(
  parameter int unsigned MAX_SIDE_LOG2 = MCBD_MAX_SIDE_LOG2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [SIDE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // chan0, chan1, chan2, chan3
  input  logic [31:0]       s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // pos_x, pos_y, out0, out1, out2, out3, two zero pad bits
  output logic [55:0]       m_axis_tdata_o,
  // mip_level
  output logic [3:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  localparam int unsigned MW     = MAX_SIDE_LOG2;
  localparam int unsigned PW     = MAX_SIDE_LOG2 + 1;
  localparam int unsigned LIDX_W = (MAX_SIDE_LOG2 > 1) ? $clog2(MAX_SIDE_LOG2) : 1;
  localparam int unsigned STORE_DEPTH = (1 << MAX_SIDE_LOG2) - 1;

  state_e state_q, state_d;

  logic [SIDE_W-1:0] side_q;
  logic [CNT_W-1:0]  chan_q;
  logic [MW-1:0]     col_q [MAX_SIDE_LOG2];
  logic [MW-1:0]     row_q [MAX_SIDE_LOG2];
  logic [LIDX_W-1:0] lvl_q;
  logic [MW-1:0]     x_q, y_q;
  logic [MW-1:0]     idx_q;
  logic [PIX_W-1:0]  px_q;

  logic              m_valid_q;
  logic [55:0]       m_data_q;
  logic [3:0]        m_user_q;
  logic              m_last_q;

  logic [SIDE_W-1:0] n_eff;
  logic [CNT_W-1:0]  ch_eff;
  logic [PIX_W-1:0]  px_in;
  logic [PW-1:0]     full, side, side_m1, idx;
  logic [MW-1:0]     cur_x, cur_y;
  logic [SIDE_W-1:0] lvl_p1;
  logic [MAX_SIDE_LOG2:0] odd_both;
  logic              more_lvl, run_end;

  logic              in_fire, rd_issue, emit, out_free, emit_fire;
  logic              held_we, pair_we;
  logic [PIX_W-1:0]  held_rd;
  logic [PAIR_W-1:0] pair_rd, pair_sum;
  logic [PIX_W-1:0]  avg;

  // Effective configuration with out-of-range values clamped.
  always_comb begin
    if (side_q == '0) begin
      n_eff = SIDE_W'(1);
    end else if (side_q > SIDE_W'(MAX_SIDE_LOG2)) begin
      n_eff = SIDE_W'(MAX_SIDE_LOG2);
    end else begin
      n_eff = side_q;
    end
    if (chan_q == '0) begin
      ch_eff = CNT_W'(1);
    end else if (chan_q > CNT_W'(MAX_CHANNELS)) begin
      ch_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      ch_eff = chan_q;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      px_in[c*CHAN_W +: CHAN_W] = (CNT_W'(c) < ch_eff) ? s_axis_tdata_i[c*CHAN_W +: CHAN_W]
                                                        : '0;
    end
  end

  // Address and counter arithmetic for the level being read.
  assign cur_x   = col_q[lvl_q];
  assign cur_y   = row_q[lvl_q];
  assign full    = PW'(1) << n_eff;
  assign side    = full >> lvl_q;
  assign side_m1 = side - PW'(1);
  assign idx     = full - side + PW'(cur_x >> 1);

  assign lvl_p1 = SIDE_W'(lvl_q) + SIDE_W'(1);

  always_comb begin
    odd_both = '0;
    for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
      odd_both[k] = col_q[k][0] & row_q[k][0];
    end
  end

  // The next level completes a block exactly when its position is odd, odd.
  assign more_lvl = lvl_p1 < n_eff;
  assign run_end  = !(more_lvl && odd_both[lvl_p1]);

  assign out_free = !m_valid_q || m_axis_tready_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!(x_q[0] && y_q[0])) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          state_d = more_lvl ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output decode of the state machine.
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_issue        = 1'b0;
    held_we         = 1'b0;
    pair_we         = 1'b0;
    emit            = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_issue        = s_axis_tvalid_i;
      end
      ST_READ: begin
        rd_issue = 1'b1;
      end
      ST_UPDATE: begin
        held_we = !x_q[0];
        pair_we = x_q[0] && !y_q[0];
        emit    = x_q[0] && y_q[0];
      end
      default: begin
      end
    endcase
  end

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_fire = emit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= SIDE_RESET;
      chan_q  <= CHAN_RESET;
      lvl_q   <= '0;
      for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SIDE_LOG2) begin
          side_q <= cfg_wdata_i;
          for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
            col_q[k] <= '0;
            row_q[k] <= '0;
          end
        end else begin
          chan_q <= cfg_wdata_i[CNT_W-1:0];
        end
      end else if (rd_issue) begin
        if (PW'(cur_x) == side_m1) begin
          col_q[lvl_q] <= '0;
          row_q[lvl_q] <= (PW'(cur_y) == side_m1) ? '0 : cur_y + MW'(1);
        end else begin
          col_q[lvl_q] <= cur_x + MW'(1);
        end
      end

      if (state_q == ST_UPDATE && state_d == ST_READ) begin
        lvl_q <= lvl_q + LIDX_W'(1);
      end else if (state_d == ST_IDLE) begin
        lvl_q <= '0;
      end

      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      x_q   <= cur_x;
      y_q   <= cur_y;
      idx_q <= idx[MW-1:0];
    end
    if (in_fire) begin
      px_q <= px_in;
    end else if (emit_fire) begin
      px_q <= avg;
    end
    if (emit_fire) begin
      m_data_q <= {2'b00, avg, POS_W'(16'(y_q >> 1)), POS_W'(16'(x_q >> 1))};
      m_user_q <= lvl_p1;
      m_last_q <= run_end;
    end
  end

  mcbd_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(STORE_DEPTH)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pair_we),
    .waddr_i(idx_q),
    .wdata_i(pair_sum),
    .re_i   (rd_issue),
    .raddr_i(idx[MW-1:0]),
    .rdata_o(pair_rd)
  );

  mcbd_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SIDE_LOG2)
  ) u_held_ram (
    .clk_i  (clk_i),
    .we_i   (held_we),
    .waddr_i(lvl_q),
    .wdata_i(px_q),
    .re_i   (rd_issue),
    .raddr_i(lvl_q),
    .rdata_o(held_rd)
  );

  mcbd_avg u_avg (
    .held_i    (held_rd),
    .px_i      (px_q),
    .pair_i    (pair_rd),
    .pair_sum_o(pair_sum),
    .avg_o     (avg)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== tb/tb.sv =====
module tb;
  import mcbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS       = MCBD_MAX_SIDE_LOG2;
  localparam int STORE_DEPTH  = (1 << LEVELS) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEM_TARGET  = 380;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [3:0]  level;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [7:0]  out0;
    logic [7:0]  out1;
    logic [7:0]  out2;
    logic [7:0]  out3;
    logic        run_end;
  } mip_pixel_t;

  // Tracks the raster position of every level, the held left pixels and the
  // pair sums, and queues the lower-level pixels each base pixel produces.
  class mip_pixel_tracker;
    int unsigned side_cfg;
    int unsigned chan_cfg;
    int unsigned col [LEVELS];
    int unsigned row [LEVELS];
    bit [7:0]    held_px [LEVELS][MAX_CHANNELS];
    bit [8:0]    pair_sum [STORE_DEPTH][MAX_CHANNELS];
    mip_pixel_t  pending_mip_pixels [$];
    int          checked;
    int          mismatches;
    int          deepest;

    function new();
      side_cfg = SIDE_RESET;
      chan_cfg = CHAN_RESET;
      foreach (col[l]) begin
        col[l] = 0;
        row[l] = 0;
      end
      checked    = 0;
      mismatches = 0;
      deepest    = 0;
    endfunction

    function void set_reg(logic index, logic [SIDE_W-1:0] value);
      if (index == CFG_SIDE_LOG2) begin
        side_cfg = value;
        foreach (col[l]) begin
          col[l] = 0;
          row[l] = 0;
        end
      end else begin
        chan_cfg = value[CNT_W-1:0];
      end
    endfunction

    function int outstanding();
      return pending_mip_pixels.size();
    endfunction

    function void take_base_pixel(logic [31:0] pixel);
      int unsigned n, ch, full, span, x, y, half, idx, s;
      int unsigned px [MAX_CHANNELS];
      mip_pixel_t  res [LEVELS];
      int          cnt;
      n    = (side_cfg < 1) ? 1 : (side_cfg > LEVELS) ? LEVELS : side_cfg;
      ch   = (chan_cfg < 1) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
      full = 1 << n;
      cnt  = 0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        px[c] = (c < ch) ? pixel[8*c +: 8] : 0;
      end
      for (int l = 0; l < n; l++) begin
        span = full >> l;
        x    = col[l];
        y    = row[l];
        half = x >> 1;
        idx  = full - span + half;
        if (x + 1 >= span) begin
          col[l] = 0;
          row[l] = (y + 1 >= span) ? 0 : y + 1;
        end else begin
          col[l] = x + 1;
        end
        if (idx >= STORE_DEPTH) break;
        if (x % 2 == 0) begin
          for (int c = 0; c < MAX_CHANNELS; c++) held_px[l][c] = 8'(px[c]);
          break;
        end
        if (y % 2 == 0) begin
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            pair_sum[idx][c] = 9'(held_px[l][c] + px[c]);
          end
          break;
        end
        // The 2x2 block is complete; its average cascades into the next level.
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          s     = pair_sum[idx][c] + held_px[l][c] + px[c] + 2;
          px[c] = (s >> 2) & 8'hFF;
        end
        res[cnt].level   = 4'(l + 1);
        res[cnt].pos_x   = 11'(half);
        res[cnt].pos_y   = 11'(y >> 1);
        res[cnt].out0    = 8'(px[0]);
        res[cnt].out1    = 8'(px[1]);
        res[cnt].out2    = 8'(px[2]);
        res[cnt].out3    = 8'(px[3]);
        res[cnt].run_end = 1'b0;
        cnt++;
        if (l + 1 > deepest) deepest = l + 1;
      end
      if (cnt > 0) res[cnt-1].run_end = 1'b1;
      for (int i = 0; i < cnt; i++) pending_mip_pixels.push_back(res[i]);
    endfunction

    function void match_mip_pixel(mip_pixel_t got);
      mip_pixel_t want;
      if (pending_mip_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: level %0d (%0d,%0d) %h %h %h %h last %b",
                   got.level, got.pos_x, got.pos_y, got.out0, got.out1, got.out2,
                   got.out3, got.run_end);
        return;
      end
      want = pending_mip_pixels.pop_front();
      checked++;
      if (got.level !== want.level || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.out0 !== want.out0 ||
          got.out1 !== want.out1 || got.out2 !== want.out2 ||
          got.out3 !== want.out3 || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d:", checked);
          $display("  expected level %0d (%0d,%0d) %h %h %h %h last %b",
                   want.level, want.pos_x, want.pos_y, want.out0, want.out1,
                   want.out2, want.out3, want.run_end);
          $display("  actual   level %0d (%0d,%0d) %h %h %h %h last %b",
                   got.level, got.pos_x, got.pos_y, got.out0, got.out1,
                   got.out2, got.out3, got.run_end);
        end
      end
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic              cfg_index_i     = CFG_SIDE_LOG2;
  logic [SIDE_W-1:0] cfg_wdata_i     = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [31:0]       s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [55:0]       m_axis_tdata_o;
  logic [3:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;

  mip_pixel_tracker tracker;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  phases      = 0;
  bit  gaps_on     = 1'b1;
  bit  held_off    = 1'b0;

  mipmap_chain_box_downsample dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, tracker.outstanding());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic write_reg(input logic index, input logic [SIDE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(index, value);
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [31:0] pixel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pixel;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.take_base_pixel(pixel);
    items_sent++;
  endtask

  // Waits for every expected result, then lets the last input's cascade finish.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int         gap;
    mip_pixel_t got;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      // One long hold-off so the block fills up and stalls its input side.
      if (!held_off && tracker.checked >= 20) begin
        gap      = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.level   = m_axis_tuser_o;
      got.pos_x   = m_axis_tdata_o[10:0];
      got.pos_y   = m_axis_tdata_o[21:11];
      got.out0    = m_axis_tdata_o[29:22];
      got.out1    = m_axis_tdata_o[37:30];
      got.out2    = m_axis_tdata_o[45:38];
      got.out3    = m_axis_tdata_o[53:46];
      got.run_end = m_axis_tlast_o;
      tracker.match_mip_pixel(got);
    end
  end

  initial begin
    int          r, side, eff, count, room;
    int unsigned cur_side;
    bit          keep_side;
    tracker  = new();
    cur_side = SIDE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest texture: saturated pixels, then rounding on every channel.
    write_reg(CFG_SIDE_LOG2, 4'd1);
    write_reg(CFG_CHANNEL_CNT, 4'd4);
    repeat (4) send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFF00_0100);
    send_pixel(32'hFF01_0000);
    send_pixel(32'hFF01_0000);
    send_pixel(32'hFE00_0101);
    settle();

    // Zero side and zero channels both act as one.
    write_reg(CFG_SIDE_LOG2, 4'd0);
    write_reg(CFG_CHANNEL_CNT, 4'd0);
    send_pixel(32'h1234_5678);
    send_pixel(32'hFFFF_FF01);
    send_pixel(32'h8080_8003);
    send_pixel(32'h7F7F_7F7F);
    settle();

    // Oversized settings clamp; a few pixels never complete a block here.
    write_reg(CFG_SIDE_LOG2, 4'd15);
    write_reg(CFG_CHANNEL_CNT, 4'd7);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel($urandom);
    settle();

    // Partial texture, cut short by the next side write.
    write_reg(CFG_SIDE_LOG2, 4'd2);
    write_reg(CFG_CHANNEL_CNT, 4'd2);
    repeat (10) send_pixel(rand_pixel());
    settle();
    phases = 4;
    cur_side = 2;

    // One whole 16x16 texture and a few pixels of the next one.
    write_reg(CFG_SIDE_LOG2, 4'd4);
    write_reg(CFG_CHANNEL_CNT, 4'd4);
    repeat (260) send_pixel(rand_pixel());
    settle();
    phases++;
    cur_side = 4;

    while (items_sent < ITEM_TARGET) begin
      keep_side = ($urandom_range(0, 3) == 0);
      if (keep_side) begin
        side = cur_side;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20)      side = 1;
        else if (r < 45) side = 2;
        else if (r < 75) side = 3;
        else if (r < 85) side = 4;
        else if (r < 90) side = 0;
        else             side = $urandom_range(12, 15);
        write_reg(CFG_SIDE_LOG2, SIDE_W'(side));
        cur_side = side;
      end
      write_reg(CFG_CHANNEL_CNT, SIDE_W'($urandom_range(0, 7)));
      eff = (side < 1) ? 1 : (side > LEVELS) ? LEVELS : side;
      if (eff <= 3)      count = $urandom_range(1, 2 << (2 * eff));
      else if (eff == 4) count = $urandom_range(16, 128);
      else               count = $urandom_range(1, 12);
      room = ITEM_TARGET + 10 - items_sent;
      if (count > room) count = room;
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (count) send_pixel(rand_pixel());
      settle();
      phases++;
    end

    $display("Sent %0d base pixels in %0d setting phases (sides 0..15, channels 0..7).",
             items_sent, phases);
    $display("Checked %0d mip pixels down to level %0d, %0d mismatches.",
             tracker.checked, tracker.deepest, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mcbd_pkg.sv
rtl/core/mcbd_ram.sv
rtl/core/mcbd_avg.sv
rtl/core/mipmap_chain_box_downsample.sv
tb/tb.sv
